// File: rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and the rotation descriptor table for the
// polycube child canonicalizer.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int MAP_BITS = 256;
    localparam int CELL_AW  = 8;
    localparam int CNT_W    = 9;
    localparam int CRD_W    = 5;
    localparam int LEN_W    = 6;
    localparam int ROTS     = 24;
    localparam int ROT_W    = 5;
    localparam int CELL_W   = 3 * CRD_W;
    localparam int DIMS_W   = 3 * CRD_W;
    localparam int DATA_W   = 272;

    typedef logic [0:5][2:0] t_desc;

    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  len_x;
        logic [LEN_W-1:0]  len_y;
        logic [LEN_W-1:0]  len_z;
        logic [2:0]        sh;
        logic [CELL_W-1:0] nc;
        logic [CNT_W-1:0]  cnt;
    } t_rot_req;

    typedef struct packed {
        logic                done;
        logic [MAP_BITS-1:0] map;
        logic [DIMS_W-1:0]   dims;
    } t_rot_res;

    // Axis order of the box lengths, then the source of each rotated coordinate.
    function automatic t_desc rot_desc(input logic [ROT_W-1:0] j);
        t_desc d;
        case (j)
            5'd0:  d = {3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2};
            5'd1:  d = {3'd0, 3'd1, 3'd2, 3'd0, 3'd4, 3'd5};
            5'd2:  d = {3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd5};
            5'd3:  d = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd2};
            5'd4:  d = {3'd1, 3'd0, 3'd2, 3'd4, 3'd0, 3'd2};
            5'd5:  d = {3'd1, 3'd0, 3'd2, 3'd1, 3'd3, 3'd2};
            5'd6:  d = {3'd2, 3'd1, 3'd0, 3'd5, 3'd1, 3'd0};
            5'd7:  d = {3'd2, 3'd0, 3'd1, 3'd5, 3'd0, 3'd4};
            5'd8:  d = {3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3};
            5'd9:  d = {3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd1};
            5'd10: d = {3'd1, 3'd0, 3'd2, 3'd1, 3'd0, 3'd5};
            5'd11: d = {3'd1, 3'd0, 3'd2, 3'd4, 3'd3, 3'd5};
            5'd12: d = {3'd2, 3'd1, 3'd0, 3'd2, 3'd1, 3'd3};
            5'd13: d = {3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1};
            5'd14: d = {3'd2, 3'd1, 3'd0, 3'd2, 3'd4, 3'd0};
            5'd15: d = {3'd2, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
            5'd16: d = {3'd0, 3'd2, 3'd1, 3'd0, 3'd2, 3'd4};
            5'd17: d = {3'd1, 3'd2, 3'd0, 3'd4, 3'd2, 3'd3};
            5'd18: d = {3'd0, 3'd2, 3'd1, 3'd3, 3'd2, 3'd1};
            5'd19: d = {3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0};
            5'd20: d = {3'd0, 3'd2, 3'd1, 3'd0, 3'd5, 3'd1};
            5'd21: d = {3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd0};
            5'd22: d = {3'd0, 3'd2, 3'd1, 3'd3, 3'd5, 3'd4};
            5'd23: d = {3'd1, 3'd2, 3'd0, 3'd1, 3'd5, 3'd3};
            default: d = {3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2};
        endcase
        return d;
    endfunction

endpackage

// File: rtl/pcc_ram.sv
// ----------------------------------------------------------------------------
// pcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcc_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/pcc_rot.sv
// ----------------------------------------------------------------------------
// pcc_rot
// Rotation engine: builds each of the 24 rotated maps of one child from the
// cell list memory and keeps the largest.
// ----------------------------------------------------------------------------
module pcc_rot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pcc_pkg::t_rot_req                   i_req,
    output logic                                o_rd_en,
    output logic [pcc_pkg::CELL_AW-1:0]         o_rd_addr,
    input  logic [pcc_pkg::CELL_W-1:0]          i_rd_data,
    output pcc_pkg::t_rot_res                   o_res
);

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_RUN, S_CMP} t_state;

    localparam int LW = pcc_pkg::LEN_W;
    localparam int CW = pcc_pkg::CRD_W;
    localparam int MB = pcc_pkg::MAP_BITS;

    t_state                      r_st, n_st;
    logic [pcc_pkg::ROT_W-1:0]   r_j, n_j;
    pcc_pkg::t_rot_req           r_req, n_req;
    logic [LW-1:0]               r_d0, n_d0, r_d1, n_d1, r_d2, n_d2;
    logic [2*LW-2:0]             r_d01, n_d01;
    logic [2:0]                  r_e3, n_e3, r_e4, n_e4, r_e5, n_e5;
    logic [MB-1:0]               r_map, n_map;
    logic [pcc_pkg::CNT_W-1:0]   r_ci, n_ci;
    logic                        r_new_done, n_new_done;
    logic                        r_q_v, n_q_v;
    logic                        r_q_new, n_q_new;
    logic [MB-1:0]               r_bmap, n_bmap;
    logic [3*LW-1:0]             r_blen, n_blen;
    logic                        r_done, n_done;

    pcc_pkg::t_desc              desc;
    logic [LW-1:0]               lv [0:2];
    logic [CW-1:0]               c [0:2];
    logic [CW-1:0]               c6 [0:5];
    logic [2*LW-1:0]             d01_full;
    logic [16:0]                 k;
    logic [MB+3*LW-1:0]          cand, best;

    always_comb begin
        desc  = pcc_pkg::rot_desc(r_j);
        lv[0] = r_req.len_x;
        lv[1] = r_req.len_y;
        lv[2] = r_req.len_z;
        d01_full = (2*LW)'(lv[desc[0][1:0]]) * (2*LW)'(lv[desc[1][1:0]]);
        for (int i = 0; i < 3; i++) begin
            if (r_q_new) begin
                c[i] = r_req.nc[i*CW +: CW];
            end else begin
                c[i] = i_rd_data[i*CW +: CW] - CW'(1) + CW'(r_req.sh[i]);
            end
            c6[i]     = c[i];
            c6[i + 3] = CW'(lv[i] - LW'(1) - LW'(c[i]));
        end
        k = 17'(c6[r_e5]) * 17'(r_d01) + 17'(c6[r_e4]) * 17'(r_d0) + 17'(c6[r_e3]);
        cand = {r_map[63:0], r_map[127:64], r_map[191:128], r_map[255:192],
                r_d0, r_d1, r_d2};
        best = {r_bmap[63:0], r_bmap[127:64], r_bmap[191:128], r_bmap[255:192],
                r_blen};
    end

    always_comb begin
        n_st       = r_st;
        n_j        = r_j;
        n_req      = r_req;
        n_d0       = r_d0;
        n_d1       = r_d1;
        n_d2       = r_d2;
        n_d01      = r_d01;
        n_e3       = r_e3;
        n_e4       = r_e4;
        n_e5       = r_e5;
        n_map      = r_map;
        n_ci       = r_ci;
        n_new_done = r_new_done;
        n_q_v      = 1'b0;
        n_q_new    = 1'b0;
        n_bmap     = r_bmap;
        n_blen     = r_blen;
        n_done     = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_ci[pcc_pkg::CELL_AW-1:0];
        case (r_st)
            S_IDLE: begin
                if (i_req.start) begin
                    n_req = i_req;
                    n_j   = '0;
                    n_st  = S_SETUP;
                end
            end
            S_SETUP: begin
                n_d0       = lv[desc[0][1:0]];
                n_d1       = lv[desc[1][1:0]];
                n_d2       = lv[desc[2][1:0]];
                n_d01      = d01_full[2*LW-2:0];
                n_e3       = desc[3];
                n_e4       = desc[4];
                n_e5       = desc[5];
                n_map      = '0;
                n_ci       = '0;
                n_new_done = 1'b0;
                n_st       = S_RUN;
            end
            S_RUN: begin
                if (r_ci < r_req.cnt) begin
                    o_rd_en = 1'b1;
                    n_ci    = r_ci + 1'b1;
                    n_q_v   = 1'b1;
                end else if (!r_new_done) begin
                    n_new_done = 1'b1;
                    n_q_v      = 1'b1;
                    n_q_new    = 1'b1;
                end else if (!r_q_v) begin
                    n_st = S_CMP;
                end
                if (r_q_v && k < 17'd256) begin
                    n_map[k[7:0]] = 1'b1;
                end
            end
            S_CMP: begin
                if (r_j == '0 || cand > best) begin
                    n_bmap = r_map;
                    n_blen = {r_d0, r_d1, r_d2};
                end
                if (r_j == pcc_pkg::ROT_W'(pcc_pkg::ROTS - 1)) begin
                    n_done = 1'b1;
                    n_st   = S_IDLE;
                end else begin
                    n_j  = r_j + 1'b1;
                    n_st = S_SETUP;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_q_v   <= 1'b0;
            r_done  <= 1'b0;
            r_j     <= '0;
        end else begin
            r_st    <= n_st;
            r_q_v   <= n_q_v;
            r_done  <= n_done;
            r_j     <= n_j;
        end
        r_req      <= n_req;
        r_d0       <= n_d0;
        r_d1       <= n_d1;
        r_d2       <= n_d2;
        r_d01      <= n_d01;
        r_e3       <= n_e3;
        r_e4       <= n_e4;
        r_e5       <= n_e5;
        r_map      <= n_map;
        r_ci       <= n_ci;
        r_new_done <= n_new_done;
        r_q_new    <= n_q_new;
        r_bmap     <= n_bmap;
        r_blen     <= n_blen;
    end

    assign o_res.done = r_done;
    assign o_res.map  = r_bmap;
    assign o_res.dims = {r_blen[CW-1:0], r_blen[LW +: CW], r_blen[2*LW +: CW]};

endmodule

// File: rtl/polycube_child_canonicalizer.sv
// ----------------------------------------------------------------------------
// polycube_child_canonicalizer
// Expands one parent polycube into its one-cube children, up to MAX_RES of
// them, and emits the canonical (largest of 24 rotations) form of each.
// ----------------------------------------------------------------------------
// Slave channel takes one parent request: box lengths and a 256-bit map.
// Master channel returns one request per child; tlast marks the final child.
// A parent with no neighbor cell returns nothing.
// Per parent: the occupied cells are first loaded into the cell list memory,
// the padded box is then scanned cell by cell, and each child is built in
// 24 rotations, each reading all N occupied cells (N being the occupied cell
// count) through the single read port of the cell list memory.
// The next parent is taken once the scan has finished and the last child
// has left the holding register; the output register then holds the final
// child until it is taken.
// Reset returns all control to idle and drops any child not yet delivered.
// A stalled receiver holds the output register and, behind it, the
// engine once one further child is ready.
// ----------------------------------------------------------------------------
module polycube_child_canonicalizer #(
    parameter int MAX_CUBES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // size_x, size_y, size_z, voxels_w0, voxels_w1, voxels_w2, voxels_w3
    input  logic [pcc_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // child_x, child_y, child_z, child_w0, child_w1, child_w2, child_w3
    output logic [pcc_pkg::DATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);

    typedef enum logic [1:0] {T_IDLE, T_FILL, T_SCAN, T_ROT} t_state;

    localparam int MAX_RES = 4 * (MAX_CUBES - 1) + 2;
    localparam int RES_W   = $clog2(MAX_RES + 1);
    localparam int CW      = pcc_pkg::CRD_W;
    localparam int PW      = pcc_pkg::LEN_W;
    localparam int MB      = pcc_pkg::MAP_BITS;
    localparam int PD_W    = MB + pcc_pkg::DIMS_W;

    t_state                     r_st, n_st;
    logic [CW-1:0]              r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic [2*CW-1:0]            r_sxy, n_sxy;
    logic [MB-1:0]              r_vox, n_vox;
    logic [CW-1:0]              r_fx, n_fx, r_fy, n_fy, r_fz, n_fz;
    logic [7:0]                 r_fk, n_fk;
    logic [pcc_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [PW-1:0]              r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic signed [16:0]         r_pk, n_pk;
    logic [RES_W-1:0]           r_nres, n_nres;
    logic                       r_pnd_v, n_pnd_v, r_pnd_rel, n_pnd_rel;
    logic                       r_pnd_last, n_pnd_last;
    logic [PD_W-1:0]            r_pnd, n_pnd;
    logic                       r_o_v, n_o_v, r_o_last, n_o_last;
    logic [PD_W-1:0]            r_o, n_o;
    pcc_pkg::t_rot_req          r_req, n_req;

    pcc_pkg::t_rot_res          rot_res;
    logic                       rd_en;
    logic [pcc_pkg::CELL_AW-1:0] rd_addr;
    logic [pcc_pkg::CELL_W-1:0] rd_data;
    logic                       wr_en;

    logic [PW-1:0]              ex, ey, ez;
    logic                       is_child, at_end, fill_end, box_ok, moving;
    logic [PW-1:0]              adv_px, adv_py, adv_pz;
    logic signed [16:0]         adv_pk, sx_s, sxy_s;
    logic [2:0]                 grow, sh;

    function automatic logic occ(input logic [PW-1:0] x, input logic [PW-1:0] y,
                                 input logic [PW-1:0] z, input logic signed [16:0] k,
                                 input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                                 input logic [CW-1:0] sz, input logic [MB-1:0] v);
        return (x != '0) && (x <= PW'(sx)) && (y != '0) && (y <= PW'(sy)) &&
               (z != '0) && (z <= PW'(sz)) && (k >= 17'sd0) && (k < 17'sd256) &&
               v[k[7:0]];
    endfunction

    assign s_axis_tready = (r_st == T_IDLE) && !r_pnd_v;
    assign m_axis_tvalid = r_o_v;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {1'b0, r_o};

    assign box_ok   = (r_sx != '0) && (r_sy != '0) && (r_sz != '0);
    assign wr_en    = (r_st == T_FILL) && box_ok && r_vox[r_fk];
    assign fill_end = !box_ok || (r_fk == 8'hff) ||
                      (r_fx == r_sx && r_fy == r_sy && r_fz == r_sz);

    always_comb begin
        ex    = PW'(r_sx) + PW'(1);
        ey    = PW'(r_sy) + PW'(1);
        ez    = PW'(r_sz) + PW'(1);
        sx_s  = 17'(r_sx);
        sxy_s = 17'(r_sxy);
        is_child = !occ(r_px, r_py, r_pz, r_pk, r_sx, r_sy, r_sz, r_vox) &&
            (occ(r_px - PW'(1), r_py, r_pz, r_pk - 17'sd1, r_sx, r_sy, r_sz, r_vox) ||
             occ(r_px + PW'(1), r_py, r_pz, r_pk + 17'sd1, r_sx, r_sy, r_sz, r_vox) ||
             occ(r_px, r_py - PW'(1), r_pz, r_pk - sx_s, r_sx, r_sy, r_sz, r_vox) ||
             occ(r_px, r_py + PW'(1), r_pz, r_pk + sx_s, r_sx, r_sy, r_sz, r_vox) ||
             occ(r_px, r_py, r_pz - PW'(1), r_pk - sxy_s, r_sx, r_sy, r_sz, r_vox) ||
             occ(r_px, r_py, r_pz + PW'(1), r_pk + sxy_s, r_sx, r_sy, r_sz, r_vox));
        at_end = (r_px == ex) && (r_py == ey) && (r_pz == ez);
        adv_px = r_px + PW'(1);
        adv_py = r_py;
        adv_pz = r_pz;
        adv_pk = r_pk + 17'sd1;
        if (r_px == ex) begin
            adv_px = '0;
            if (r_py == ey) begin
                adv_py = '0;
                adv_pz = r_pz + PW'(1);
                adv_pk = r_pk - (sx_s + sx_s + 17'sd1);
            end else begin
                adv_py = r_py + PW'(1);
                adv_pk = r_pk - 17'sd1;
            end
        end
        grow = 3'b000;
        sh   = 3'b000;
        if (r_px == '0) begin
            grow[0] = 1'b1; sh[0] = 1'b1;
        end else if (r_py == '0) begin
            grow[1] = 1'b1; sh[1] = 1'b1;
        end else if (r_pz == '0) begin
            grow[2] = 1'b1; sh[2] = 1'b1;
        end else if (r_px == ex) begin
            grow[0] = 1'b1;
        end else if (r_py == ey) begin
            grow[1] = 1'b1;
        end else if (r_pz == ez) begin
            grow[2] = 1'b1;
        end
    end

    always_comb begin
        n_st       = r_st;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_sz       = r_sz;
        n_sxy      = r_sxy;
        n_vox      = r_vox;
        n_fx       = r_fx;
        n_fy       = r_fy;
        n_fz       = r_fz;
        n_fk       = r_fk;
        n_cnt      = r_cnt;
        n_px       = r_px;
        n_py       = r_py;
        n_pz       = r_pz;
        n_pk       = r_pk;
        n_nres     = r_nres;
        n_pnd_v    = r_pnd_v;
        n_pnd_rel  = r_pnd_rel;
        n_pnd_last = r_pnd_last;
        n_pnd      = r_pnd;
        n_o_v      = r_o_v;
        n_o_last   = r_o_last;
        n_o        = r_o;
        n_req      = r_req;
        n_req.start = 1'b0;

        moving = r_pnd_v && r_pnd_rel && (!r_o_v || m_axis_tready);
        if (moving) begin
            n_o      = r_pnd;
            n_o_last = r_pnd_last;
            n_o_v    = 1'b1;
            n_pnd_v  = 1'b0;
        end else if (m_axis_tready) begin
            n_o_v = 1'b0;
        end

        case (r_st)
            T_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_sx   = s_axis_tdata[4:0];
                    n_sy   = s_axis_tdata[9:5];
                    n_sz   = s_axis_tdata[14:10];
                    n_vox  = s_axis_tdata[270:15];
                    n_sxy  = (2*CW)'(s_axis_tdata[4:0]) * (2*CW)'(s_axis_tdata[9:5]);
                    n_fx   = CW'(1);
                    n_fy   = CW'(1);
                    n_fz   = CW'(1);
                    n_fk   = '0;
                    n_cnt  = '0;
                    n_nres = '0;
                    n_st   = T_FILL;
                end
            end
            T_FILL: begin
                if (wr_en) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_fk = r_fk + 1'b1;
                if (r_fx == r_sx) begin
                    n_fx = CW'(1);
                    if (r_fy == r_sy) begin
                        n_fy = CW'(1);
                        n_fz = r_fz + CW'(1);
                    end else begin
                        n_fy = r_fy + CW'(1);
                    end
                end else begin
                    n_fx = r_fx + CW'(1);
                end
                if (fill_end) begin
                    n_px = '0;
                    n_py = '0;
                    n_pz = '0;
                    n_pk = -(17'sd1 + sx_s + sxy_s);
                    n_st = T_SCAN;
                end
            end
            T_SCAN: begin
                if (r_nres == RES_W'(MAX_RES)) begin
                    n_st = T_IDLE;
                end else if (is_child) begin
                    if (r_pnd_v) begin
                        if (!r_pnd_rel) begin
                            n_pnd_rel  = 1'b1;
                            n_pnd_last = 1'b0;
                        end
                    end else begin
                        n_req.start = 1'b1;
                        n_req.len_x = PW'(r_sx) + PW'(grow[0]);
                        n_req.len_y = PW'(r_sy) + PW'(grow[1]);
                        n_req.len_z = PW'(r_sz) + PW'(grow[2]);
                        n_req.sh    = sh;
                        n_req.nc    = {CW'(r_pz + PW'(sh[2]) - PW'(1)),
                                       CW'(r_py + PW'(sh[1]) - PW'(1)),
                                       CW'(r_px + PW'(sh[0]) - PW'(1))};
                        n_req.cnt   = r_cnt;
                        n_st        = T_ROT;
                    end
                end else if (at_end) begin
                    if (r_pnd_v && !r_pnd_rel) begin
                        n_pnd_rel  = 1'b1;
                        n_pnd_last = 1'b1;
                    end
                    n_st = T_IDLE;
                end else begin
                    n_px = adv_px;
                    n_py = adv_py;
                    n_pz = adv_pz;
                    n_pk = adv_pk;
                end
            end
            T_ROT: begin
                if (rot_res.done) begin
                    n_pnd   = {rot_res.map, rot_res.dims};
                    n_pnd_v = 1'b1;
                    n_nres  = r_nres + 1'b1;
                    if (at_end || r_nres == RES_W'(MAX_RES - 1)) begin
                        n_pnd_rel  = 1'b1;
                        n_pnd_last = 1'b1;
                        n_st       = T_IDLE;
                    end else begin
                        n_pnd_rel  = 1'b0;
                        n_pnd_last = 1'b0;
                        n_px = adv_px;
                        n_py = adv_py;
                        n_pz = adv_pz;
                        n_pk = adv_pk;
                        n_st = T_SCAN;
                    end
                end
            end
            default: n_st = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= T_IDLE;
            r_pnd_v   <= 1'b0;
            r_pnd_rel <= 1'b0;
            r_o_v     <= 1'b0;
            r_nres    <= '0;
            r_req     <= '0;
        end else begin
            r_st      <= n_st;
            r_pnd_v   <= n_pnd_v;
            r_pnd_rel <= n_pnd_rel;
            r_o_v     <= n_o_v;
            r_nres    <= n_nres;
            r_req     <= n_req;
        end
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_sz       <= n_sz;
        r_sxy      <= n_sxy;
        r_vox      <= n_vox;
        r_fx       <= n_fx;
        r_fy       <= n_fy;
        r_fz       <= n_fz;
        r_fk       <= n_fk;
        r_cnt      <= n_cnt;
        r_px       <= n_px;
        r_py       <= n_py;
        r_pz       <= n_pz;
        r_pk       <= n_pk;
        r_pnd_last <= n_pnd_last;
        r_pnd      <= n_pnd;
        r_o_last   <= n_o_last;
        r_o        <= n_o;
    end

    pcc_ram #(
        .WIDTH (pcc_pkg::CELL_W),
        .DEPTH (pcc_pkg::MAP_BITS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cnt[pcc_pkg::CELL_AW-1:0]),
        .i_wdata ({r_fz, r_fy, r_fx}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    pcc_rot u_rot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_req),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_res     (rot_res)
    );

endmodule
